[rtl/sdg_pkg.sv]
// Package for the serial day to Gregorian date unit.
// Holds period constants, the microcode format, the program ROM and the month table.
// No dependencies.
package sdg_pkg;

  localparam int unsigned DayW   = 23;
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DomW   = 5;
  localparam int unsigned PcW    = 3;

  localparam logic [DayW:0]    EpochOffset = 24'd693594;
  localparam logic [DayW-1:0]  DaysY1      = 23'd365;
  localparam logic [DayW-1:0]  DaysY4      = 23'd1461;
  localparam logic [DayW-1:0]  DaysY100    = 23'd36524;
  localparam logic [DayW-1:0]  DaysY400    = 23'd146097;

  localparam logic [MonthW-1:0] LastMonth  = 4'd11;
  localparam logic [1:0]        LastCentury = 2'd3;
  localparam logic [1:0]        LastYear    = 2'd3;
  localparam logic [4:0]        LastQuad    = 5'd24;

  // Micro-operations. Each one names both the datapath action and the
  // jump condition that goes with it.
  typedef enum logic [2:0] {
    OP_WAIT  = 3'd0,
    OP_CHECK = 3'd1,
    OP_P400  = 3'd2,
    OP_P100  = 3'd3,
    OP_P4    = 3'd4,
    OP_P1    = 3'd5,
    OP_MONTH = 3'd6,
    OP_EMIT  = 3'd7
  } op_t;

  // Program step addresses.
  localparam logic [PcW-1:0] StIdle  = 3'd0;
  localparam logic [PcW-1:0] StCheck = 3'd1;
  localparam logic [PcW-1:0] StP400  = 3'd2;
  localparam logic [PcW-1:0] StP100  = 3'd3;
  localparam logic [PcW-1:0] StP4    = 3'd4;
  localparam logic [PcW-1:0] StP1    = 3'd5;
  localparam logic [PcW-1:0] StMonth = 3'd6;
  localparam logic [PcW-1:0] StEmit  = 3'd7;

  typedef struct packed {
    op_t            op;
    logic [PcW-1:0] jmp;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } dp_ctrl_t;

  typedef struct packed {
    logic take;
    logic date_ok;
  } dp_stat_t;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DomW-1:0]   day_of_month;
    logic              leap_year;
    logic              date_valid;
  } date_t;

  // Program ROM: when the step's condition holds, jump to jmp, otherwise
  // fall through to the next step (the last step wraps to the first).
  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      StIdle:  w = '{op: OP_WAIT,  jmp: StIdle};
      StCheck: w = '{op: OP_CHECK, jmp: StEmit};
      StP400:  w = '{op: OP_P400,  jmp: StP400};
      StP100:  w = '{op: OP_P100,  jmp: StP100};
      StP4:    w = '{op: OP_P4,    jmp: StP4};
      StP1:    w = '{op: OP_P1,    jmp: StP1};
      StMonth: w = '{op: OP_MONTH, jmp: StMonth};
      StEmit:  w = '{op: OP_EMIT,  jmp: StEmit};
      default: w = '{op: OP_WAIT,  jmp: StIdle};
    endcase
    return w;
  endfunction

  // Month length for a zero-based month index.
  function automatic logic [DomW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DomW-1:0] len;
    case (m)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/sdg_if.sv]
// Valid/ready channel interfaces for the serial day to Gregorian date unit.
// Depends on sdg_pkg for field widths.
interface sdg_in_if;
  import sdg_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [DayW-1:0] day_number;
  modport source (output valid, output day_number, input ready);
  modport sink   (input valid, input day_number, output ready);
endinterface

interface sdg_out_if;
  import sdg_pkg::*;
  logic              valid;
  logic              ready;
  logic [YearW-1:0]  year;
  logic [MonthW-1:0] month;
  logic [DomW-1:0]   day_of_month;
  logic              leap_year;
  logic              date_valid;
  modport source (output valid, output year, output month, output day_of_month,
                  output leap_year, output date_valid, input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input leap_year, input date_valid, output ready);
endinterface

[rtl/sdg_datapath.sv]
// Datapath of the date unit: day remainder, year accumulator, period counters
// and month index, stepped by the micro-operation from the sequencer.
// Depends on sdg_pkg.
module sdg_datapath (
  input  logic                           clk,
  input  sdg_pkg::dp_ctrl_t              ctrl,
  input  logic signed [sdg_pkg::DayW-1:0] day_number,
  output sdg_pkg::dp_stat_t              stat,
  output sdg_pkg::date_t                 result
);
  import sdg_pkg::*;

  logic [DayW-1:0]   d;
  logic [YearW-1:0]  y;
  logic [1:0]        b;
  logic [4:0]        c;
  logic [1:0]        q1;
  logic [MonthW-1:0] m;
  logic              date_ok;

  logic signed [DayW:0] t;
  logic [DayW-1:0]      k;
  logic [YearW-1:0]     inc;
  logic                 ge;
  logic                 take;
  logic                 leap;

  assign t = {day_number[DayW-1], day_number} + $signed(EpochOffset);

  // Leap when the year is last in its four-year group, unless it closes a
  // century that is not the last of its 400-year cycle.
  assign leap = (q1 == LastYear) && ((c != LastQuad) || (b == LastCentury));

  always_comb begin
    k   = '0;
    inc = '0;
    case (ctrl.op)
      OP_P400:  begin k = DaysY400; inc = 14'd400; end
      OP_P100:  begin k = DaysY100; inc = 14'd100; end
      OP_P4:    begin k = DaysY4;   inc = 14'd4;   end
      OP_P1:    begin k = DaysY1;   inc = 14'd1;   end
      OP_MONTH: begin k = {{(DayW-DomW){1'b0}}, month_len(m, leap)}; end
      default:  begin k = '0; inc = '0; end
    endcase
    ge = (d >= k);
    case (ctrl.op)
      OP_P400:  take = ge;
      OP_P100:  take = ge && (b != LastCentury);
      OP_P4:    take = ge;
      OP_P1:    take = ge && (q1 != LastYear);
      OP_MONTH: take = ge && (m != LastMonth);
      default:  take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      d       <= t[DayW-1:0] - {{(DayW-1){1'b0}}, 1'b1};
      y       <= {{(YearW-1){1'b0}}, 1'b1};
      b       <= '0;
      c       <= '0;
      q1      <= '0;
      m       <= '0;
      date_ok <= !t[DayW] && (t != '0);
    end else if (take) begin
      d <= d - k;
      y <= y + inc;
      case (ctrl.op)
        OP_P100:  b  <= b + 2'd1;
        OP_P4:    c  <= c + 5'd1;
        OP_P1:    q1 <= q1 + 2'd1;
        OP_MONTH: m  <= m + 4'd1;
        default:  ;
      endcase
    end
  end

  assign stat.take    = take;
  assign stat.date_ok = date_ok;

  assign result.year         = date_ok ? y : '0;
  assign result.month        = date_ok ? m + 4'd1 : '0;
  assign result.day_of_month = date_ok ? d[DomW-1:0] + 5'd1 : '0;
  assign result.leap_year    = date_ok && leap;
  assign result.date_valid   = date_ok;

endmodule

[rtl/serial_day_to_gregorian_date_unit.sv]
// Top level of the serial day to Gregorian date unit: microcode sequencer,
// output register and handshakes. Depends on sdg_pkg, sdg_if and sdg_datapath.
//
//   Channel    Dir   Word contents
//   ---------  ----  -----------------------------------------------------
//   day_in     in    day_number (23-bit signed, days since 1899-12-30)
//   date_out   out   year, month, day_of_month, leap_year, date_valid
//
// One word is converted at a time. The time a word takes is set by the
// number of passes through the single subtractor: one per 400-year period
// (up to 33 over the input range), up to 3 centuries, 24 four-year groups,
// 3 years and 11 months, plus the fall-through step that ends each loop and
// the accept, check and emit steps. A day number before year 1 goes from the check step straight to emit.
// Reset is synchronous and clears only the step counter and the output valid.
// A stall on date_out holds the emit step until the output register frees; a
// new word is taken as soon as the finished result sits in that register.
module serial_day_to_gregorian_date_unit (
  input logic      clk,
  input logic      rst,
  sdg_in_if.sink   day_in,
  sdg_out_if.source date_out
);
  import sdg_pkg::*;

  logic [PcW-1:0] pc;
  logic [PcW-1:0] pc_next;
  uword_t         uw;
  dp_ctrl_t       ctrl;
  dp_stat_t       stat;
  date_t          result;
  date_t          out_word;
  logic           out_valid;
  logic           out_free;
  logic           cond;

  // Fetch the control word for the current step straight from the ROM.
  assign uw = ucode(pc);

  assign out_free = !out_valid || date_out.ready;

  assign day_in.ready = (uw.op == OP_WAIT);

  assign ctrl.op   = uw.op;
  assign ctrl.load = day_in.valid && (uw.op == OP_WAIT);

  // Jump condition for each micro-operation. On a true condition the
  // sequencer goes to the word's jump target, otherwise to the next step.
  always_comb begin
    case (uw.op)
      OP_WAIT:  cond = !day_in.valid;
      OP_CHECK: cond = !stat.date_ok;
      OP_EMIT:  cond = !out_free;
      default:  cond = stat.take;
    endcase
    pc_next = cond ? uw.jmp : pc + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= StIdle;
    end else begin
      pc <= pc_next;
    end
  end

  // Output register: loaded in the emit step once the previous word is gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.op == OP_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (date_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == OP_EMIT && out_free) begin
      out_word <= result;
    end
  end

  sdg_datapath u_datapath (
    .clk        (clk),
    .ctrl       (ctrl),
    .day_number (day_in.day_number),
    .stat       (stat),
    .result     (result)
  );

  assign date_out.valid        = out_valid;
  assign date_out.year         = out_word.year;
  assign date_out.month        = out_word.month;
  assign date_out.day_of_month = out_word.day_of_month;
  assign date_out.leap_year    = out_word.leap_year;
  assign date_out.date_valid   = out_word.date_valid;

endmodule

[tb/serial_day_to_gregorian_date_unit_tb.sv]
// Testbench for the serial day to Gregorian date unit: drives day numbers on
// day_in, predicts each date word and checks date_out against it in order.
// Depends on sdg_pkg, sdg_if and serial_day_to_gregorian_date_unit.
module serial_day_to_gregorian_date_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdg_pkg::*;

  // Calendar period lengths in days, kept here as plain integers so the
  // predictor does its own arithmetic.
  localparam int EpochDays   = 693594;
  localparam int DaysYear    = 365;
  localparam int DaysQuad    = 1461;
  localparam int DaysCentury = 36524;
  localparam int DaysEra     = 146097;
  localparam int DayMin      = -(1 << (DayW - 1));
  localparam int DayMax      = (1 << (DayW - 1)) - 1;
  localparam int LastSerial  = 2958465;   // 9999-12-31

  logic clk;
  logic rst;

  sdg_in_if  day_in ();
  sdg_out_if date_out ();

  serial_day_to_gregorian_date_unit dut (
    .clk      (clk),
    .rst      (rst),
    .day_in   (day_in),
    .date_out (date_out)
  );

  // Dates still owed by the block, oldest first, with the day numbers that
  // produced them so that a mismatch can name its input.
  date_t                  owed_dates[$];
  logic signed [DayW-1:0] owed_days[$];

  int errors            = 0;
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int hold_request      = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Converts a day number the way the block should: shift to a zero-based
  // count from 0001-01-01, peel off 400, 100, 4 and 1 year periods, then walk
  // the months of the year that is left.
  function automatic date_t convert_day(input logic signed [DayW-1:0] dn);
    date_t r;
    int    t;
    int    d;
    int    y;
    int    q;
    int    m;
    int    len;
    logic  leap;
    int    month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    r = '0;
    t = int'(dn) + EpochDays;
    if (t > 0) begin
      d = t - 1;
      y = 1;
      q = d / DaysEra;
      d -= q * DaysEra;
      y += q * 400;
      q = d / DaysCentury;
      d -= q * DaysCentury;
      // The last day of a 400-year era belongs to the fourth century.
      if (q == 4) begin
        q = 3;
        d += DaysCentury;
      end
      y += q * 100;
      q = d / DaysQuad;
      d -= q * DaysQuad;
      y += q * 4;
      q = d / DaysYear;
      d -= q * DaysYear;
      // The leap day at the end of a four-year group stays in its fourth year.
      if (q == 4) begin
        q = 3;
        d += DaysYear;
      end
      y += q;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      m = 0;
      len = month_days[0];
      while (m < 11 && d >= len) begin
        d -= len;
        m++;
        len = month_days[m] + ((m == 1 && leap) ? 1 : 0);
      end
      r.year         = YearW'(y);
      r.month        = MonthW'(m + 1);
      r.day_of_month = DomW'(d + 1);
      r.leap_year    = leap;
      r.date_valid   = 1'b1;
    end
    return r;
  endfunction

  // Offers one day number, with random idle cycles first, and records the
  // date it should turn into once the word is taken. Valid stays high after
  // acceptance so that back-to-back words need no extra cycle.
  task automatic send_day(input logic signed [DayW-1:0] dn);
    while ($urandom_range(99) < sender_idle_pct) begin
      day_in.valid <= 1'b0;
      @(posedge clk);
    end
    day_in.valid      <= 1'b1;
    day_in.day_number <= dn;
    do @(posedge clk); while (!day_in.ready);
    owed_dates.push_back(convert_day(dn));
    owed_days.push_back(dn);
  endtask

  // Receiver: checks every accepted date word against the oldest owed date,
  // then picks the next ready value. A hold request keeps ready low for that
  // many cycles, counted here, so the block backs up into its input.
  initial begin : receiver
    date_t                  want;
    date_t                  got;
    logic signed [DayW-1:0] dn;
    int                     hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && date_out.valid && date_out.ready) begin
        got = '{year: date_out.year, month: date_out.month,
                day_of_month: date_out.day_of_month,
                leap_year: date_out.leap_year, date_valid: date_out.date_valid};
        if (owed_dates.size() == 0) begin
          errors++;
          $display("%0t ns: date word with none owed: %0d-%0d-%0d leap %0b valid %0b",
                   $time, got.year, got.month, got.day_of_month,
                   got.leap_year, got.date_valid);
        end else begin
          want = owed_dates.pop_front();
          dn   = owed_days.pop_front();
          if (got !== want) begin
            errors++;
            $display({"%0t ns: day %0d: expected %0d-%0d-%0d leap %0b valid %0b,",
                      " got %0d-%0d-%0d leap %0b valid %0b"},
                     $time, dn, want.year, want.month, want.day_of_month,
                     want.leap_year, want.date_valid, got.year, got.month,
                     got.day_of_month, got.leap_year, got.date_valid);
          end
        end
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        date_out.ready <= 1'b0;
      end else begin
        date_out.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Picks a day number. Part of the draws cover the whole 23-bit field so that
  // every bit toggles, part stay in the documented range, and the rest land
  // next to period boundaries where the overflow corrections kick in.
  function automatic logic signed [DayW-1:0] pick_day();
    int sel;
    int period;
    int k;
    int off;
    sel = $urandom_range(9);
    if (sel < 4) begin
      return DayW'($urandom);
    end else if (sel < 8) begin
      return DayW'(int'($urandom_range(LastSerial + EpochDays)) - EpochDays);
    end else begin
      case ($urandom_range(3))
        0:       period = DaysYear;
        1:       period = DaysQuad;
        2:       period = DaysCentury;
        default: period = DaysEra;
      endcase
      k   = $urandom_range((DayMax + EpochDays) / period);
      off = int'($urandom_range(2)) - 1;
      return DayW'(period * k + off - EpochDays);
    end
  endfunction

  // Field extremes, both sides of year 1, the epoch, the 1900 and 2000
  // February cases, the last day of four-year groups and 400-year eras,
  // the top of the documented range and the top of the field.
  task automatic test_directed();
    int days[$] = '{DayMin, -EpochDays - 1, -EpochDays, -EpochDays + 1,
                    -EpochDays + 1460, -EpochDays + 1461, -EpochDays + 1462,
                    -EpochDays + 146096, -EpochDays + 146097, -109206,
                    -1, 0, 1, 2, 60, 61, 36585, 36586, 36891,
                    LastSerial, LastSerial + 1, DayMax, 'h2AAAAA, -'h2AAAAB};
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    foreach (days[i]) send_day(DayW'(days[i]));
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    sender_idle_pct   = s_pct;
    receiver_idle_pct = r_pct;
    repeat (count) send_day(pick_day());
  endtask

  // The receiver stops for a long stretch while words keep coming, so the
  // output register and the converter fill and day_in must drop ready.
  task automatic test_backpressure();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_request      = 400;
    repeat (16) send_day(pick_day());
  endtask

  initial begin : stimulus
    rst               = 1'b1;
    day_in.valid      = 1'b0;
    day_in.day_number = '0;
    date_out.ready    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(530, 14, 72);
    test_random(530, 72, 14);
    test_random(530, 0, 0);
    test_backpressure();

    day_in.valid <= 1'b0;
    while (owed_dates.size() != 0) @(posedge clk);
    // Leave room for a stray extra word to show up.
    repeat (100) @(posedge clk);

    if (errors == 0) begin
      $display("[serial_day_to_gregorian_date_unit] OK");
    end else begin
      $display("[serial_day_to_gregorian_date_unit] ERROR");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin : watchdog
    #4_000_000;
    $display("[serial_day_to_gregorian_date_unit] ERROR");
    $finish;
  end

endmodule
